>>> hw/rtl/kpbs_pkg.sv
// ----------------------------------------------------------------------------
// kpbs_pkg
// shared types and constants of the k-mer prefix bucket search unit
// ----------------------------------------------------------------------------
package kpbs_pkg;

  localparam int KEY_W        = 64;
  localparam int VALUE_W      = 56;
  localparam int ADDR_W       = 20;
  localparam int BUCKET_VAL_W = 21;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int KMER_LEN_W   = 6;
  localparam int PREFIX_W     = 5;
  localparam int TAIL_LEN_W   = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_KMER_LENGTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PREFIX_BITS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_BYTE_COUNT = 2'd2;

  localparam logic [KMER_LEN_W-1:0] KMER_LENGTH_RST     = 6'd32;
  localparam logic [KMER_LEN_W-1:0] KMER_LENGTH_MAX     = 6'd32;
  localparam logic [PREFIX_W-1:0]   PREFIX_BITS_RST     = 5'd16;
  localparam logic [TAIL_LEN_W-1:0] TAIL_BYTE_COUNT_RST = 3'd6;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_BUCKET = 2'd0,
    MODE_WR_TAIL   = 2'd1,
    MODE_FIND      = 2'd2,
    MODE_UNUSED    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_WRITE_DONE = 2'd0,
    STAT_FOUND      = 2'd1,
    STAT_NOT_FOUND  = 2'd2,
    STAT_BAD_ADDR   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_HI,
    S_BOUNDS,
    S_SEARCH,
    S_RESP
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_hi;
    logic bounds;
    logic search;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic find_req;
    logic range_ok;
    logic hit;
    logic more;
  } sts_t;

endpackage

>>> hw/rtl/kpbs_ctrl.sv
// ----------------------------------------------------------------------------
// kpbs_ctrl
// sequencer of the search unit: item intake, table writes, bucket bound
// reads, binary search probes and the output word handshake
// ----------------------------------------------------------------------------
module kpbs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  kpbs_pkg::sts_t  sts_i,
  output kpbs_pkg::cmd_t  cmd_o
);

  kpbs_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      kpbs_pkg::S_IDLE: begin
        if (in_valid_i) state_d = kpbs_pkg::S_EXEC;
      end
      kpbs_pkg::S_EXEC: begin
        state_d = sts_i.find_req ? kpbs_pkg::S_RD_HI : kpbs_pkg::S_RESP;
      end
      kpbs_pkg::S_RD_HI: begin
        state_d = kpbs_pkg::S_BOUNDS;
      end
      kpbs_pkg::S_BOUNDS: begin
        state_d = sts_i.range_ok ? kpbs_pkg::S_SEARCH : kpbs_pkg::S_RESP;
      end
      kpbs_pkg::S_SEARCH: begin
        if (sts_i.hit || !sts_i.more) state_d = kpbs_pkg::S_RESP;
      end
      kpbs_pkg::S_RESP: begin
        if (out_free) state_d = kpbs_pkg::S_IDLE;
      end
      default: begin
        state_d = kpbs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      kpbs_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      kpbs_pkg::S_EXEC:   cmd_o.exec   = 1'b1;
      kpbs_pkg::S_RD_HI:  cmd_o.rd_hi  = 1'b1;
      kpbs_pkg::S_BOUNDS: cmd_o.bounds = 1'b1;
      kpbs_pkg::S_SEARCH: cmd_o.search = 1'b1;
      kpbs_pkg::S_RESP:   cmd_o.load_out = out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kpbs_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten while still pending");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == kpbs_pkg::S_EXEC))
    else $error("accepted word not executed");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.exec, cmd_o.rd_hi, cmd_o.bounds, cmd_o.search,
              cmd_o.load_out}))
    else $error("more than one datapath step commanded");
`endif

endmodule

>>> hw/rtl/kpbs_datapath.sv
// ----------------------------------------------------------------------------
// kpbs_datapath
// configuration registers, bucket start table, tail store, search bounds
// and result registers of the search unit
// ----------------------------------------------------------------------------
module kpbs_datapath #(
  parameter int MAX_PREFIX_BITS = 16,
  parameter int TABLE_DEPTH     = 1048576
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [kpbs_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [kpbs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [kpbs_pkg::MODE_W-1:0]          mode_i,
  input  logic [kpbs_pkg::ADDR_W-1:0]          write_address_i,
  input  logic [kpbs_pkg::VALUE_W-1:0]         write_value_i,
  input  logic [kpbs_pkg::KEY_W-1:0]           kmer_key_i,
  output logic [kpbs_pkg::STATUS_W-1:0]        status_o,
  output logic [kpbs_pkg::ADDR_W-1:0]          entry_index_o,
  input  kpbs_pkg::cmd_t                       cmd_i,
  output kpbs_pkg::sts_t                       sts_o
);

  localparam int BUCKET_DEPTH = (1 << MAX_PREFIX_BITS) + 2;
  localparam int BA_W         = $clog2(BUCKET_DEPTH);
  localparam int TA_W         = $clog2(TABLE_DEPTH);
  localparam int TD_W         = $clog2(TABLE_DEPTH + 1);
  localparam int LH_W = (TD_W < kpbs_pkg::BUCKET_VAL_W) ? TD_W : kpbs_pkg::BUCKET_VAL_W;
  localparam int SUM_W        = LH_W + 1;

  // configuration
  logic [kpbs_pkg::KMER_LEN_W-1:0] kl_q;
  logic [kpbs_pkg::PREFIX_W-1:0]   pf_q;
  logic [kpbs_pkg::TAIL_LEN_W-1:0] tb_q;

  // captured word
  kpbs_pkg::mode_e                   mode_q;
  logic [kpbs_pkg::ADDR_W-1:0]       waddr_q;
  logic [kpbs_pkg::VALUE_W-1:0]      wval_q;
  logic [BA_W-1:0]                   head_q;
  logic [kpbs_pkg::VALUE_W-1:0]      want_q;
  logic [kpbs_pkg::VALUE_W-1:0]      tmask_q;

  // search state
  logic [LH_W-1:0] lo_q, hi_q, pos_q;
  kpbs_pkg::status_e               res_status_q;
  logic [kpbs_pkg::ADDR_W-1:0]     res_index_q;
  logic [kpbs_pkg::STATUS_W-1:0]   out_status_q;
  logic [kpbs_pkg::ADDR_W-1:0]     out_index_q;

  // memories
  logic [kpbs_pkg::BUCKET_VAL_W-1:0] bucket_mem [BUCKET_DEPTH];
  logic [kpbs_pkg::VALUE_W-1:0]      tail_ram [TABLE_DEPTH];
  logic [kpbs_pkg::BUCKET_VAL_W-1:0] bkt_rdata_q;
  logic [kpbs_pkg::VALUE_W-1:0]      tail_rdata_q;

  // key split
  logic [kpbs_pkg::KMER_LEN_W-1:0] kl_eff;
  logic [6:0]                      key_bits, pb_eff, shamt;
  logic [kpbs_pkg::KEY_W-1:0]      head_mask;
  logic [BA_W-1:0]                 head_c;
  logic [kpbs_pkg::VALUE_W-1:0]    tmask_c;

  // write decode
  logic            bucket_ok, tail_ok, bucket_we, tail_we;
  logic [BA_W-1:0] bkt_raddr;
  logic [TA_W-1:0] tail_raddr;

  // search
  logic [LH_W-1:0]              bkt_clamp, lo_n, hi_n, mid_b, mid_s;
  logic [SUM_W-1:0]             sum_b, sum_s;
  logic [kpbs_pkg::VALUE_W-1:0] have;
  logic                         hit, less;

  function automatic logic [LH_W-1:0] clamp_start(input logic [kpbs_pkg::BUCKET_VAL_W-1:0] v);
    logic [LH_W-1:0] r;
    if (32'(v) > 32'(TABLE_DEPTH)) begin
      r = LH_W'(TABLE_DEPTH);
    end else begin
      r = LH_W'(v);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kl_q <= kpbs_pkg::KMER_LENGTH_RST;
      pf_q <= kpbs_pkg::PREFIX_BITS_RST;
      tb_q <= kpbs_pkg::TAIL_BYTE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kpbs_pkg::CFG_KMER_LENGTH:     kl_q <= cfg_data_i[kpbs_pkg::KMER_LEN_W-1:0];
        kpbs_pkg::CFG_PREFIX_BITS:     pf_q <= cfg_data_i[kpbs_pkg::PREFIX_W-1:0];
        kpbs_pkg::CFG_TAIL_BYTE_COUNT: tb_q <= cfg_data_i[kpbs_pkg::TAIL_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    kl_eff   = (kl_q > kpbs_pkg::KMER_LENGTH_MAX) ? kpbs_pkg::KMER_LENGTH_MAX : kl_q;
    key_bits = {kl_eff, 1'b0};
    pb_eff   = 7'(pf_q);
    if (pb_eff > 7'(MAX_PREFIX_BITS)) pb_eff = 7'(MAX_PREFIX_BITS);
    if (pb_eff > key_bits) pb_eff = key_bits;
    shamt     = key_bits - pb_eff;
    head_mask = (64'd1 << pb_eff) - 64'd1;
    head_c    = BA_W'((kmer_key_i >> shamt) & head_mask);
    tmask_c   = (56'd1 << {tb_q, 3'b000}) - 56'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= kpbs_pkg::mode_e'(mode_i);
      waddr_q <= write_address_i;
      wval_q  <= write_value_i;
      head_q  <= head_c;
      want_q  <= kmer_key_i[kpbs_pkg::VALUE_W-1:0] & tmask_c;
      tmask_q <= tmask_c;
    end
  end

  assign bucket_ok  = 32'(waddr_q) < 32'(BUCKET_DEPTH);
  assign tail_ok    = 32'(waddr_q) < 32'(TABLE_DEPTH);
  assign bucket_we  = cmd_i.exec && (mode_q == kpbs_pkg::MODE_WR_BUCKET) && bucket_ok;
  assign tail_we    = cmd_i.exec && (mode_q == kpbs_pkg::MODE_WR_TAIL) && tail_ok;
  assign bkt_raddr  = cmd_i.rd_hi ? head_q + BA_W'(1) : head_q;

  always_ff @(posedge clk_i) begin
    if (bucket_we) begin
      bucket_mem[BA_W'(waddr_q)] <= wval_q[kpbs_pkg::BUCKET_VAL_W-1:0];
    end
    bkt_rdata_q <= bucket_mem[bkt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) begin
      tail_ram[TA_W'(waddr_q)] <= wval_q;
    end
    tail_rdata_q <= tail_ram[tail_raddr];
  end

  always_comb begin
    bkt_clamp  = clamp_start(bkt_rdata_q);
    sum_b      = SUM_W'(lo_q) + SUM_W'(bkt_clamp);
    mid_b      = LH_W'(sum_b >> 1);
    have       = tail_rdata_q & tmask_q;
    hit        = (have == want_q);
    less       = (have < want_q);
    lo_n       = less ? pos_q + LH_W'(1) : lo_q;
    hi_n       = less ? hi_q : pos_q;
    sum_s      = SUM_W'(lo_n) + SUM_W'(hi_n);
    mid_s      = LH_W'(sum_s >> 1);
    tail_raddr = cmd_i.bounds ? TA_W'(mid_b) : TA_W'(mid_s);
  end

  assign sts_o.find_req = (mode_q == kpbs_pkg::MODE_FIND);
  assign sts_o.range_ok = (lo_q < bkt_clamp);
  assign sts_o.hit      = hit;
  assign sts_o.more     = (lo_n < hi_n);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_hi) begin
      lo_q <= bkt_clamp;
    end
    if (cmd_i.bounds) begin
      hi_q  <= bkt_clamp;
      pos_q <= mid_b;
    end
    if (cmd_i.search) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      pos_q <= mid_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_index_q <= '0;
      case (mode_q)
        kpbs_pkg::MODE_WR_BUCKET:
          res_status_q <= bucket_ok ? kpbs_pkg::STAT_WRITE_DONE : kpbs_pkg::STAT_BAD_ADDR;
        kpbs_pkg::MODE_WR_TAIL:
          res_status_q <= tail_ok ? kpbs_pkg::STAT_WRITE_DONE : kpbs_pkg::STAT_BAD_ADDR;
        kpbs_pkg::MODE_FIND:
          res_status_q <= kpbs_pkg::STAT_NOT_FOUND;
        default:
          res_status_q <= kpbs_pkg::STAT_BAD_ADDR;
      endcase
    end
    if (cmd_i.bounds) begin
      res_status_q <= kpbs_pkg::STAT_NOT_FOUND;
      res_index_q  <= '0;
    end
    if (cmd_i.search && hit) begin
      res_status_q <= kpbs_pkg::STAT_FOUND;
      res_index_q  <= kpbs_pkg::ADDR_W'(pos_q);
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
    end
  end

  assign status_o      = out_status_q;
  assign entry_index_o = out_index_q;

`ifndef NO_ASSERTIONS
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.search |-> ((pos_q >= lo_q) && (pos_q < hi_q)))
    else $error("probe index outside the search window");
`endif

endmodule

>>> hw/rtl/kmer_prefix_bucket_binary_search_unit.sv
// ----------------------------------------------------------------------------
// kmer_prefix_bucket_binary_search_unit
// membership lookup of packed k-mers in a prefix bucketed sorted tail store
// ----------------------------------------------------------------------------
// write word: capture, exec (table write and status), then load into the output register
// find word: capture, exec, bucket bound reads, bounds check, p search probes, output load
//   (p = 0 for an empty region, at most floor(log2 of region size) + 1)
// a new word is taken once the previous result sits in the output register
// reset restores control and configuration defaults; both tables are undefined
//   until written
module kmer_prefix_bucket_binary_search_unit #(
  parameter int MAX_PREFIX_BITS = 16,
  parameter int TABLE_DEPTH     = 1048576
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kpbs_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [kpbs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [kpbs_pkg::MODE_W-1:0]      mode_i,
  input  logic [kpbs_pkg::ADDR_W-1:0]      write_address_i,
  input  logic [kpbs_pkg::VALUE_W-1:0]     write_value_i,
  input  logic [kpbs_pkg::KEY_W-1:0]       kmer_key_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [kpbs_pkg::STATUS_W-1:0]    status_o,
  output logic [kpbs_pkg::ADDR_W-1:0]      entry_index_o
);

  kpbs_pkg::cmd_t cmd;
  kpbs_pkg::sts_t sts;

  kpbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kpbs_datapath #(
    .MAX_PREFIX_BITS (MAX_PREFIX_BITS),
    .TABLE_DEPTH     (TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .write_address_i (write_address_i),
    .write_value_i   (write_value_i),
    .kmer_key_i      (kmer_key_i),
    .status_o        (status_o),
    .entry_index_o   (entry_index_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

>>> sim/tb_kmer_prefix_bucket_binary_search_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kmer_prefix_bucket_binary_search_unit
// Self-checking bench for the prefix bucketed k-mer lookup unit. It loads
// bucket starts and sorted tail regions, then runs finds that hit and miss
// under a sweep of k-mer length, prefix width and tail byte settings. A
// software copy of both tables predicts every reply. Both handshakes see
// random gaps, with one burst phase that has none.
// ----------------------------------------------------------------------------
module tb_kmer_prefix_bucket_binary_search_unit;

  localparam int unsigned MAX_PREFIX_BITS = 16;
  localparam int unsigned TABLE_DEPTH     = 1048576;
  localparam int unsigned BUCKET_DEPTH    = (1 << MAX_PREFIX_BITS) + 2;
  localparam int unsigned SETTLE_CYCLES   = 40;

  typedef struct {
    kpbs_pkg::status_e           status;
    logic [kpbs_pkg::ADDR_W-1:0] slot;
  } reply_t;

  typedef struct {
    logic                        legal;
    kpbs_pkg::status_e           status;
    logic [kpbs_pkg::ADDR_W-1:0] slot;
  } search_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [kpbs_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [kpbs_pkg::CFG_DATA_W-1:0]  cfg_data_i;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [kpbs_pkg::MODE_W-1:0]      mode_i;
  logic [kpbs_pkg::ADDR_W-1:0]      write_address_i;
  logic [kpbs_pkg::VALUE_W-1:0]     write_value_i;
  logic [kpbs_pkg::KEY_W-1:0]       kmer_key_i;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic [kpbs_pkg::STATUS_W-1:0]    status_o;
  logic [kpbs_pkg::ADDR_W-1:0]      entry_index_o;

  logic [kpbs_pkg::BUCKET_VAL_W-1:0] bucket_starts [int unsigned];
  logic [kpbs_pkg::VALUE_W-1:0]      tail_words [int unsigned];
  logic [kpbs_pkg::KMER_LEN_W-1:0]   cfg_kmer_len;
  logic [kpbs_pkg::PREFIX_W-1:0]     cfg_prefix;
  logic [kpbs_pkg::TAIL_LEN_W-1:0]   cfg_tail_len;

  reply_t      awaited_replies [$];
  int unsigned mismatch_count = 0;
  int unsigned ready_hold = 0;
  logic        burst_mode = 1'b0;
  int unsigned win_base, win_count, win_first, win_last;

  kmer_prefix_bucket_binary_search_unit #(
    .MAX_PREFIX_BITS(MAX_PREFIX_BITS),
    .TABLE_DEPTH    (TABLE_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .write_address_i(write_address_i),
    .write_value_i  (write_value_i),
    .kmer_key_i     (kmer_key_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .entry_index_o  (entry_index_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [kpbs_pkg::VALUE_W-1:0] rand56();
    return kpbs_pkg::VALUE_W'({$urandom, $urandom});
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // effective key width and bucket select width
  function automatic void key_geometry(output int unsigned kbits, output int unsigned pbits);
    kbits = 2 * ((cfg_kmer_len > kpbs_pkg::KMER_LENGTH_MAX) ?
                 int'(kpbs_pkg::KMER_LENGTH_MAX) : int'(cfg_kmer_len));
    pbits = cfg_prefix;
    if (pbits > MAX_PREFIX_BITS) pbits = MAX_PREFIX_BITS;
    if (pbits > kbits) pbits = kbits;
  endfunction

  function automatic logic [63:0] tail_mask();
    return (64'd1 << (8 * cfg_tail_len)) - 64'd1;
  endfunction

  // binary search over the mirrored tables; legal is low if it would touch an unwritten entry
  function automatic search_t search_key(logic [63:0] key);
    search_t     r;
    int unsigned kbits, pbits, head, lo, hi, mid;
    logic [63:0] mask, want, have;
    r.legal  = 1'b1;
    r.status = kpbs_pkg::STAT_NOT_FOUND;
    r.slot   = '0;
    key_geometry(kbits, pbits);
    head = 0;
    if (pbits > 0) head = int'((key >> (kbits - pbits)) & ((64'd1 << pbits) - 64'd1));
    mask = tail_mask();
    want = key & mask;
    if (!bucket_starts.exists(head) || !bucket_starts.exists(head + 1)) begin
      r.legal = 1'b0;
      return r;
    end
    lo = bucket_starts[head];
    hi = bucket_starts[head + 1];
    if (lo > TABLE_DEPTH) lo = TABLE_DEPTH;
    if (hi > TABLE_DEPTH) hi = TABLE_DEPTH;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (!tail_words.exists(mid)) begin
        r.legal = 1'b0;
        return r;
      end
      have = tail_words[mid] & mask;
      if (have == want) begin
        r.status = kpbs_pkg::STAT_FOUND;
        r.slot   = kpbs_pkg::ADDR_W'(mid);
        return r;
      end
      if (have < want) lo = mid + 1;
      else hi = mid;
    end
    return r;
  endfunction

  // apply one accepted word to the mirrored tables and queue its reply
  function automatic void commit_word(kpbs_pkg::mode_e mode, logic [kpbs_pkg::ADDR_W-1:0] addr,
                                      logic [kpbs_pkg::VALUE_W-1:0] val, logic [63:0] key);
    reply_t  rep;
    search_t s;
    rep.status = kpbs_pkg::STAT_BAD_ADDR;
    rep.slot   = '0;
    case (mode)
      kpbs_pkg::MODE_WR_BUCKET: begin
        if (addr < BUCKET_DEPTH) begin
          bucket_starts[addr] = val[kpbs_pkg::BUCKET_VAL_W-1:0];
          rep.status = kpbs_pkg::STAT_WRITE_DONE;
        end
      end
      kpbs_pkg::MODE_WR_TAIL: begin
        if (addr < TABLE_DEPTH) begin
          tail_words[addr] = val;
          rep.status = kpbs_pkg::STAT_WRITE_DONE;
        end
      end
      kpbs_pkg::MODE_FIND: begin
        s = search_key(key);
        rep.status = s.status;
        rep.slot   = s.slot;
      end
      default: ;
    endcase
    awaited_replies.push_back(rep);
  endfunction

  // key whose head selects the given bucket, low bits taken from low
  function automatic logic [63:0] key_for_bucket(int unsigned head, logic [63:0] low,
                                                 logic [63:0] noise);
    int unsigned kbits, pbits, sh;
    logic [63:0] key, mask, hmask;
    key_geometry(kbits, pbits);
    mask = tail_mask();
    key  = (noise & ~mask) | (low & mask);
    if (pbits > 0) begin
      sh    = kbits - pbits;
      hmask = ((64'd1 << pbits) - 64'd1) << sh;
      key   = (key & ~hmask) | ((64'(head) << sh) & hmask);
    end
    return key;
  endfunction

  task automatic send_word(kpbs_pkg::mode_e mode, logic [kpbs_pkg::ADDR_W-1:0] addr,
                           logic [kpbs_pkg::VALUE_W-1:0] val, logic [63:0] key);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= mode;
    write_address_i <= addr;
    write_value_i   <= val;
    kmer_key_i      <= key;
    do @(posedge clk_i); while (!in_ready_o);
    commit_word(mode, addr, val, key);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_config(logic [kpbs_pkg::KMER_LEN_W-1:0] kmer_len,
                            logic [kpbs_pkg::PREFIX_W-1:0] prefix,
                            logic [kpbs_pkg::TAIL_LEN_W-1:0] tail_len);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= kpbs_pkg::CFG_KMER_LENGTH;
    cfg_data_i  <= kmer_len;
    @(posedge clk_i);
    cfg_index_i <= kpbs_pkg::CFG_PREFIX_BITS;
    cfg_data_i  <= {1'($urandom), prefix};
    @(posedge clk_i);
    cfg_index_i <= kpbs_pkg::CFG_TAIL_BYTE_COUNT;
    cfg_data_i  <= {3'($urandom), tail_len};
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    cfg_kmer_len = kmer_len;
    cfg_prefix   = prefix;
    cfg_tail_len = tail_len;
  endtask

  // a run of adjacent buckets, each with a region sorted under the current tail mask
  task automatic load_window(int unsigned max_fill);
    int unsigned kbits, pbits, span, next, fill, b, j;
    logic [63:0] mask;
    logic [kpbs_pkg::VALUE_W-1:0] v;
    logic [kpbs_pkg::VALUE_W-1:0] sorted [$];
    key_geometry(kbits, pbits);
    mask      = tail_mask();
    span      = 1 << pbits;
    win_count = $urandom_range(1, (span < 6) ? span : 6);
    win_base  = $urandom_range(0, span - win_count);
    next      = $urandom_range(0, TABLE_DEPTH - 8 * max_fill);
    win_first = next;
    for (b = 0; b <= win_count; b++) begin
      v = rand56();
      v[kpbs_pkg::BUCKET_VAL_W-1:0] = kpbs_pkg::BUCKET_VAL_W'(next);
      send_word(kpbs_pkg::MODE_WR_BUCKET, kpbs_pkg::ADDR_W'(win_base + b), v, rand64());
      if (b < win_count) begin
        fill = $urandom_range(0, max_fill);
        sorted.delete();
        repeat (fill) begin
          v = rand56();
          j = 0;
          while (j < sorted.size() && (64'(sorted[j]) & mask) <= (64'(v) & mask)) j++;
          sorted.insert(j, v);
        end
        foreach (sorted[k]) begin
          send_word(kpbs_pkg::MODE_WR_TAIL, kpbs_pkg::ADDR_W'(next + k), sorted[k], rand64());
        end
        next += fill;
      end
    end
    win_last = next;
  endtask

  task automatic run_phase(logic [kpbs_pkg::KMER_LEN_W-1:0] kmer_len,
                           logic [kpbs_pkg::PREFIX_W-1:0] prefix,
                           logic [kpbs_pkg::TAIL_LEN_W-1:0] tail_len, int unsigned count);
    int unsigned pick, b, lo, hi;
    logic [63:0] key, alt, low;
    logic [kpbs_pkg::ADDR_W-1:0] addr;
    search_t s;
    set_config(kmer_len, prefix, tail_len);
    load_window(12);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      addr = kpbs_pkg::ADDR_W'($urandom);
      if (pick < 70) begin
        b   = win_base + $urandom_range(0, win_count - 1);
        lo  = bucket_starts[b];
        hi  = bucket_starts[b + 1];
        low = rand64();
        if (hi > lo && $urandom_range(0, 3) != 0) low = tail_words[$urandom_range(lo, hi - 1)];
        key = key_for_bucket(b, low, rand64());
        if (pick >= 60) begin
          alt = rand64();
          s   = search_key(alt);
          if (s.legal) key = alt;
        end
        s = search_key(key);
        if (s.legal) send_word(kpbs_pkg::MODE_FIND, addr, rand56(), key);
        else send_word(kpbs_pkg::MODE_UNUSED, addr, rand56(), key);
      end else if (pick < 80) begin
        if ($urandom_range(0, 1) && win_last > win_first) begin
          addr = kpbs_pkg::ADDR_W'($urandom_range(win_first, win_last - 1));
        end
        send_word(kpbs_pkg::MODE_WR_TAIL, addr, rand56(), rand64());
      end else if (pick < 88) begin
        addr = kpbs_pkg::ADDR_W'($urandom_range(0, BUCKET_DEPTH - 1));
        if (addr >= win_base && addr <= win_base + win_count) begin
          addr = kpbs_pkg::ADDR_W'($urandom_range(BUCKET_DEPTH, TABLE_DEPTH - 1));
        end
        send_word(kpbs_pkg::MODE_WR_BUCKET, addr, rand56(), rand64());
      end else if (pick < 94) begin
        addr = kpbs_pkg::ADDR_W'($urandom_range(BUCKET_DEPTH, TABLE_DEPTH - 1));
        send_word(kpbs_pkg::MODE_WR_BUCKET, addr, rand56(), rand64());
      end else begin
        send_word(kpbs_pkg::MODE_UNUSED, addr, rand56(), rand64());
      end
    end
  endtask

  task automatic test_write_status();
    send_word(kpbs_pkg::MODE_WR_BUCKET, kpbs_pkg::ADDR_W'(BUCKET_DEPTH - 1), '1, '1);
    send_word(kpbs_pkg::MODE_WR_BUCKET, kpbs_pkg::ADDR_W'(BUCKET_DEPTH), '0, '0);
    send_word(kpbs_pkg::MODE_WR_BUCKET, '1, '0, '0);
    send_word(kpbs_pkg::MODE_UNUSED, '1, '1, '1);
    send_word(kpbs_pkg::MODE_WR_TAIL, '1, '1, '0);
    send_word(kpbs_pkg::MODE_WR_TAIL, '0, '0, '1);
  endtask

  // top buckets: a region clamped at the store end, an empty one past the end, a reversed one
  task automatic test_region_bounds();
    send_word(kpbs_pkg::MODE_WR_BUCKET, 20'd65533, 56'd1048572, '0);
    send_word(kpbs_pkg::MODE_WR_BUCKET, 20'd65534, 56'h1F_FFFF, '0);
    send_word(kpbs_pkg::MODE_WR_BUCKET, 20'd65535, 56'h10_0005, '0);
    send_word(kpbs_pkg::MODE_WR_BUCKET, 20'd65536, 56'hFF_FFFF_FFE0_0005, '0);
    send_word(kpbs_pkg::MODE_WR_TAIL, 20'd1048572, 56'h00_0000_0000_0000, '0);
    send_word(kpbs_pkg::MODE_WR_TAIL, 20'd1048573, 56'h00_1234_5678_9ABC, '0);
    send_word(kpbs_pkg::MODE_WR_TAIL, 20'd1048574, 56'hAA_8000_0000_0000, '0);
    send_word(kpbs_pkg::MODE_WR_TAIL, 20'd1048575, 56'hFF_FFFF_FFFF_FFFF, '0);
    send_word(kpbs_pkg::MODE_FIND, '1, '1, {16'hFFFD, 48'h0});
    send_word(kpbs_pkg::MODE_FIND, '0, '0, {16'hFFFD, 48'hFFFF_FFFF_FFFF});
    send_word(kpbs_pkg::MODE_FIND, '0, '0, {16'hFFFD, 48'h8000_0000_0000});
    send_word(kpbs_pkg::MODE_FIND, '0, '0, {16'hFFFD, 48'h1234_5678_9ABC});
    send_word(kpbs_pkg::MODE_FIND, '0, '0, {16'hFFFD, 48'h0000_0000_0005});
    send_word(kpbs_pkg::MODE_FIND, '0, '0, {16'hFFFE, 48'h0});
    send_word(kpbs_pkg::MODE_FIND, '0, '0, {16'hFFFF, 48'hFFFF_FFFF_FFFF});
  endtask

  task automatic test_config_sweep();
    run_phase(6'd32, 5'd16, 3'd6, 60);
    run_phase(6'd32, 5'd16, 3'd7, 60);
    run_phase(6'd1, 5'd0, 3'd1, 60);
    run_phase(6'd0, 5'd9, 3'd3, 60);
    run_phase(6'd63, 5'd31, 3'd0, 60);
    run_phase(6'd10, 5'd20, 3'd2, 60);
    run_phase(6'd4, 5'd16, 3'd5, 60);
    run_phase(6'd32, 5'd1, 3'd4, 60);
    repeat (3) begin
      run_phase(kpbs_pkg::KMER_LEN_W'($urandom), kpbs_pkg::PREFIX_W'($urandom),
                kpbs_pkg::TAIL_LEN_W'($urandom), 60);
    end
  endtask

  task automatic test_back_to_back();
    burst_mode = 1'b1;
    run_phase(6'd32, 5'd16, 3'd6, 60);
    wait_idle();
    burst_mode = 1'b0;
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected word, status %0d entry_index %0d",
                   $time, status_o, entry_index_o);
          mismatch_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            mismatch_count++;
          end
          if (entry_index_o !== want.slot) begin
            $display("%0t: entry_index expected %0d actual %0d",
                     $time, want.slot, entry_index_o);
            mismatch_count++;
          end
        end
      end
      if (ready_hold > 0) begin
        out_ready_i <= 1'b0;
        ready_hold--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 25) ready_hold = pick_gap();
      end
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    mode_i          <= '0;
    write_address_i <= '0;
    write_value_i   <= '0;
    kmer_key_i      <= '0;
    cfg_kmer_len    = kpbs_pkg::KMER_LENGTH_RST;
    cfg_prefix      = kpbs_pkg::PREFIX_BITS_RST;
    cfg_tail_len    = kpbs_pkg::TAIL_BYTE_COUNT_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_write_status();
    test_region_bounds();
    test_config_sweep();
    test_back_to_back();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("kmer_prefix_bucket_binary_search_unit: match");
    end else begin
      $display("kmer_prefix_bucket_binary_search_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("kmer_prefix_bucket_binary_search_unit: mismatch");
    $finish;
  end

endmodule
